// File: design/slt_pkg.sv
// Shared types and constants for the sorted list table.
package slt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 31;
	localparam int ECOUNT_W     = 7;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_SEARCH = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_DELETED  = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_FOUND    = 3'd5,
		ST_ABSENT   = 3'd6,
		ST_CLEARED  = 3'd7
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [ECOUNT_W-1:0] entry_count;
	} rsp_t;

endpackage

// File: design/slt_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/sorted_list_table.sv
// Sorted list table: bounded ascending multiset held in one RAM, with insert/delete/search/clear.
//
// A command word is taken when start is high and busy is low; exactly one result word follows,
// shown on rsp for one cycle while done is high. The receiver cannot stall, so the result must
// be taken in that cycle. Insert, and delete or search on a non-empty table, make one forward pass
// over the stored entries in the entry RAM, one entry per cycle, set by the single registered RAM read port.
// Clear, insert into a full table, and delete or search on an empty table answer without a pass,
// straight from the idle state. busy drops in the done cycle, so the next command can be taken
// while the result is shown. No clearing pass after reset is needed: only entries below the count
// are ever read.
module sorted_list_table #(
	parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  slt_pkg::cmd_t cmd,
	output logic          done,
	output slt_pkg::rsp_t rsp
);

	import slt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;      // valid entries
	func_t              op_q;
	logic [VALUE_W-1:0] val_q;
	logic [CW-1:0]      rd_q;         // next position to issue
	logic [CW-1:0]      last_q;       // final position of the pass
	logic               vld_s1;       // position p_s1 has its data on rdata
	logic [CW-1:0]      p_s1;
	logic               found_q;      // insert: slot taken; delete/search: match seen
	logic [VALUE_W-1:0] carry_q;      // insert: entry being shifted up
	logic               done_q;
	rsp_t               rsp_q;

	// RAM ports
	logic               we;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] wdata;
	logic               re;
	logic [VALUE_W-1:0] rdata;

	logic               issue;
	logic               accept;
	logic               virt;         // insert's slot past the end, treated as +inf
	logic               ge;
	logic               match;
	logic               found_n;
	logic               last_hit;

	assign accept = start && (state_q == S_IDLE);
	assign issue  = (state_q == S_RUN) && (rd_q <= last_q);
	assign re     = issue && (rd_q < count_q);

	assign virt   = (p_s1 == count_q);
	assign ge     = virt || (rdata >= val_q);
	assign match  = !virt && (rdata == val_q);
	assign last_hit = vld_s1 && (p_s1 == last_q);

	// Write side of the pass. Writes always trail the read pointer, so no
	// read ever meets an address written in the same cycle.
	always_comb begin
		we      = 1'b0;
		waddr   = p_s1[AW-1:0];
		wdata   = carry_q;
		found_n = found_q;
		if (vld_s1) begin
			case (op_q)
				FN_INSERT: begin
					if (!found_q) begin
						if (ge) begin
							we      = 1'b1;
							wdata   = val_q;
							found_n = 1'b1;
						end
					end else begin
						we = 1'b1;
					end
				end
				FN_DELETE: begin
					if (found_q) begin
						// close the gap: move entry down by one
						we    = 1'b1;
						waddr = AW'(p_s1 - CW'(1));
						wdata = rdata;
					end else if (match) begin
						found_n = 1'b1;
					end
				end
				FN_SEARCH: begin
					if (match) begin
						found_n = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	slt_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			rd_q    <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			p_s1   <= rd_q;
			if (issue) begin
				rd_q <= rd_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= cmd.func;
						val_q   <= cmd.value;
						rd_q    <= '0;
						found_q <= 1'b0;
						case (cmd.func)
							FN_CLEAR: begin
								count_q           <= '0;
								done_q            <= 1'b1;
								rsp_q.status      <= ST_CLEARED;
								rsp_q.entry_count <= '0;
							end
							FN_INSERT: begin
								if (count_q >= CAP_C) begin
									done_q            <= 1'b1;
									rsp_q.status      <= ST_FULL;
									rsp_q.entry_count <= ECOUNT_W'(count_q);
								end else begin
									last_q  <= count_q;
									state_q <= S_RUN;
								end
							end
							FN_DELETE: begin
								if (count_q == '0) begin
									done_q            <= 1'b1;
									rsp_q.status      <= ST_EMPTY;
									rsp_q.entry_count <= '0;
								end else begin
									last_q  <= count_q - CW'(1);
									state_q <= S_RUN;
								end
							end
							FN_SEARCH: begin
								if (count_q == '0) begin
									done_q            <= 1'b1;
									rsp_q.status      <= ST_ABSENT;
									rsp_q.entry_count <= '0;
								end else begin
									last_q  <= count_q - CW'(1);
									state_q <= S_RUN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RUN: begin
					if (vld_s1) begin
						found_q <= found_n;
						if (op_q == FN_INSERT) begin
							carry_q <= rdata;
						end
					end
					if (last_hit) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						case (op_q)
							FN_INSERT: begin
								count_q           <= count_q + CW'(1);
								rsp_q.status      <= ST_INSERTED;
								rsp_q.entry_count <= ECOUNT_W'(count_q + CW'(1));
							end
							FN_DELETE: begin
								if (found_n) begin
									count_q           <= count_q - CW'(1);
									rsp_q.status      <= ST_DELETED;
									rsp_q.entry_count <= ECOUNT_W'(count_q - CW'(1));
								end else begin
									rsp_q.status      <= ST_NOTFOUND;
									rsp_q.entry_count <= ECOUNT_W'(count_q);
								end
							end
							default: begin
								rsp_q.status      <= found_n ? ST_FOUND : ST_ABSENT;
								rsp_q.entry_count <= ECOUNT_W'(count_q);
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// a result only appears once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_write_run: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_RUN))
		else $error("RAM write outside a pass");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (state_q == S_RUN)) |-> (p_s1 <= last_q))
		else $error("pass ran past its last position");

endmodule
